/* sv/lesf_pkg.sv */
// Shared types and constants for the largest empty square finder.
// Holds configuration register indexes, field widths and reset values; no dependencies.
package lesf_pkg;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH    = 2'd0,
    CFG_GRID_HEIGHT   = 2'd1,
    CFG_EMPTY_CHAR    = 2'd2,
    CFG_OBSTACLE_CHAR = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SIZE_OUT_W  = 11;
  localparam int unsigned POS_OUT_W   = 10;

  localparam logic [CFG_DATA_W-1:0] GRID_DIM_RST   = 11'd1;
  localparam logic [CHAR_W-1:0]     EMPTY_CHAR_RST = 8'd46;

endpackage

/* sv/largest_empty_square_finder_top.sv */
// Largest empty square finder: maximal-square scoring over a streamed grid.
// Depends on lesf_pkg; holds the line buffer, scoring stage and result register.
// The grid's last cell passes the scoring stage, then the result register.
// Throughput: one cell per cycle while no result beat waits on out_ready, set by the
// single scoring stage and one line-buffer read plus one write (read-after-write forwarded).
// Reset: synchronous active-low rst_n clears control and config; line buffer is not cleared.
module largest_empty_square_finder_top
  import lesf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_cell_char,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SIZE_OUT_W-1:0] out_square_size,
  output logic [POS_OUT_W-1:0]  out_top_row,
  output logic [POS_OUT_W-1:0]  out_left_col,
  output logic                  out_grid_done
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);

  logic [CFG_DATA_W-1:0] grid_width_r, grid_height_r;
  logic [CHAR_W-1:0]     empty_char_r;

  logic [31:0] w_eff, h_eff;
  logic        row_end, grid_end, in_acc;
  logic [CW-1:0] col_index_r;
  logic [RW-1:0] row_index_r;

  logic          s1_v_r, s1_empty_r, s1_first_r, s1_grid_end_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_fire;

  logic [SW-1:0] mem [MAX_WIDTH];
  logic [SW-1:0] rd_data_r;
  logic          byp_v_r;
  logic [SW-1:0] byp_score_r;

  logic [SW-1:0] left_r, diag_r, up, min_lu, min3, score;
  logic [SW-1:0] best_size_r, best_size_nxt;
  logic [RW-1:0] best_row_r, best_row_nxt;
  logic [CW-1:0] best_col_r, best_col_nxt;
  logic [31:0]   top_full, left_full;

  logic                  out_valid_r;
  logic [SIZE_OUT_W-1:0] out_size_r;
  logic [POS_OUT_W-1:0]  out_top_r, out_left_r;

  // Configuration; the obstacle code scores like any non-empty code, so drop it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_DIM_RST;
      grid_height_r <= GRID_DIM_RST;
      empty_char_r  <= EMPTY_CHAR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:    grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT:   grid_height_r <= cfg_data;
        CFG_EMPTY_CHAR:    empty_char_r  <= cfg_data[CHAR_W-1:0];
        CFG_OBSTACLE_CHAR: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (grid_width_r == '0)              w_eff = 32'd1;
    else if (32'(grid_width_r) > MAX_WIDTH)       w_eff = MAX_WIDTH;
    else                                          w_eff = 32'(grid_width_r);
    priority if (grid_height_r == '0)             h_eff = 32'd1;
    else if (32'(grid_height_r) > MAX_HEIGHT)     h_eff = MAX_HEIGHT;
    else                                          h_eff = 32'(grid_height_r);
  end

  assign row_end  = (32'(col_index_r) + 32'd1) >= w_eff;
  assign grid_end = row_end && ((32'(row_index_r) + 32'd1) >= h_eff);

  assign s1_fire  = s1_v_r && (!s1_grid_end_r || !out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_fire;
  assign in_acc   = in_valid && in_ready;

  // Scan position of the next beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_index_r <= '0;
      row_index_r <= '0;
    end else if (in_acc) begin
      if (grid_end) begin
        col_index_r <= '0;
        row_index_r <= '0;
      end else if (row_end) begin
        col_index_r <= '0;
        row_index_r <= row_index_r + 1'b1;
      end else begin
        col_index_r <= col_index_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_empty_r    <= (in_cell_char == empty_char_r);
      s1_first_r    <= (col_index_r == '0) || (row_index_r == '0);
      s1_grid_end_r <= grid_end;
      s1_col_r      <= col_index_r;
      s1_row_r      <= row_index_r;
      byp_v_r       <= s1_fire && (s1_col_r == col_index_r);
      byp_score_r   <= score;
    end
  end

  // Line buffer: one read at accept, one write as the scored cell retires.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[col_index_r];
    end
    if (s1_fire) begin
      mem[s1_col_r] <= score;
    end
  end

  assign up     = byp_v_r ? byp_score_r : rd_data_r;
  assign min_lu = (left_r < up) ? left_r : up;
  assign min3   = (min_lu < diag_r) ? min_lu : diag_r;

  always_comb begin
    if (!s1_empty_r)     score = '0;
    else if (s1_first_r) score = SW'(1);
    else                 score = min3 + 1'b1;
  end

  always_comb begin
    best_size_nxt = best_size_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    if (score > best_size_r) begin
      best_size_nxt = score;
      best_row_nxt  = s1_row_r;
      best_col_nxt  = s1_col_r;
    end
  end

  assign top_full  = 32'(best_row_nxt) + 32'd1 - 32'(best_size_nxt);
  assign left_full = 32'(best_col_nxt) + 32'd1 - 32'(best_size_nxt);

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      left_r <= score;
      diag_r <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_fire) begin
      if (s1_grid_end_r) begin
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        best_size_r <= best_size_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_grid_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_grid_end_r) begin
      if (best_size_nxt == '0) begin
        out_size_r <= '0;
        out_top_r  <= '0;
        out_left_r <= '0;
      end else begin
        out_size_r <= SIZE_OUT_W'(best_size_nxt);
        out_top_r  <= top_full[POS_OUT_W-1:0];
        out_left_r <= left_full[POS_OUT_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_square_size = out_size_r;
  assign out_top_row     = out_top_r;
  assign out_left_col    = out_left_r;
  assign out_grid_done   = 1'b1;

endmodule

/* bench/tb_largest_empty_square_finder_top.sv */
// Testbench for largest_empty_square_finder_top: streams character grids through the
// valid/ready ports and checks every square result against a scoring model kept here.
// Depends on lesf_pkg and the top-level RTL only.
module tb_largest_empty_square_finder_top import lesf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 1024;
  localparam int DRAIN = 4;
  localparam int RANDOM_CELLS = 1120;
  localparam int RANDOM_GRIDS = 40;
  localparam logic [CHAR_W-1:0] OBSTACLE_RST = 8'd111;

  typedef struct packed {
    logic [SIZE_OUT_W-1:0] square_size;
    logic [POS_OUT_W-1:0]  top_row;
    logic [POS_OUT_W-1:0]  left_col;
    logic                  grid_done;
  } square_t;

  class square_book;
    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [CHAR_W-1:0]     empty_code, obstacle_code;
    int unsigned           row_above [MAX_DIM];
    bit                    col_seen [MAX_DIM];
    int unsigned           left_sc, diag_sc, col_at, row_at, best_sz, best_row, best_col;
    square_t               due[$];
    int                    errors, cells, grids, biggest;

    function new();
      width_reg = GRID_DIM_RST;
      height_reg = GRID_DIM_RST;
      empty_code = EMPTY_CHAR_RST;
      obstacle_code = OBSTACLE_RST;
      foreach (row_above[i]) begin
        row_above[i] = 0;
        col_seen[i] = 1'b0;
      end
      errors = 0;
      cells = 0;
      grids = 0;
      biggest = 0;
      restart();
    endfunction

    function void restart();
      left_sc = 0;
      diag_sc = 0;
      col_at = 0;
      row_at = 0;
      best_sz = 0;
      best_row = 0;
      best_col = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
    endfunction

    function int unsigned min3(int unsigned a, int unsigned b, int unsigned c);
      int unsigned m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_GRID_WIDTH:    width_reg = v;
        CFG_GRID_HEIGHT:   height_reg = v;
        CFG_EMPTY_CHAR:    empty_code = v[CHAR_W-1:0];
        CFG_OBSTACLE_CHAR: obstacle_code = v[CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    function bit cols_ready(logic [CFG_DATA_W-1:0] v);
      int unsigned n;
      n = clamp_dim(v);
      for (int i = 0; i < n; i++)
        if (!col_seen[i]) return 1'b0;
      return 1'b1;
    endfunction

    function bit note_cell(logic [CHAR_W-1:0] ch);
      int unsigned w, h, up, sc;
      square_t r;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      up = row_above[col_at];
      sc = 0;
      cells++;
      if (ch == empty_code) begin
        if (row_at == 0 || col_at == 0) sc = 1;
        else sc = min3(left_sc, up, diag_sc) + 1;
      end
      if (sc > best_sz) begin
        best_sz = sc;
        best_row = row_at;
        best_col = col_at;
      end
      row_above[col_at] = sc;
      col_seen[col_at] = 1'b1;
      diag_sc = up;
      left_sc = sc;
      if (col_at + 1 < w) begin
        col_at++;
        return 1'b0;
      end
      if (row_at + 1 < h) begin
        col_at = 0;
        row_at++;
        left_sc = 0;
        diag_sc = 0;
        return 1'b0;
      end
      r.square_size = SIZE_OUT_W'(best_sz);
      r.top_row = (best_sz == 0) ? '0 : POS_OUT_W'(best_row + 1 - best_sz);
      r.left_col = (best_sz == 0) ? '0 : POS_OUT_W'(best_col + 1 - best_sz);
      r.grid_done = 1'b1;
      due.push_back(r);
      grids++;
      if (best_sz > biggest) biggest = best_sz;
      restart();
      return 1'b1;
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(square_t got);
      square_t want;
      if (due.size() == 0) begin
        report($sformatf("result beat with nothing expected (size %0d)", got.square_size));
        return;
      end
      want = due.pop_front();
      if (got.square_size !== want.square_size)
        report($sformatf("square_size %0d, want %0d", got.square_size, want.square_size));
      if (got.top_row !== want.top_row)
        report($sformatf("top_row %0d, want %0d", got.top_row, want.top_row));
      if (got.left_col !== want.left_col)
        report($sformatf("left_col %0d, want %0d", got.left_col, want.left_col));
      if (got.grid_done !== want.grid_done)
        report($sformatf("grid_done %b, want %b", got.grid_done, want.grid_done));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_cell_char;
  logic                  out_valid;
  logic                  out_ready;
  logic [SIZE_OUT_W-1:0] out_square_size;
  logic [POS_OUT_W-1:0]  out_top_row;
  logic [POS_OUT_W-1:0]  out_left_col;
  logic                  out_grid_done;

  square_book book;
  bit         steady;
  int         resizes;
  int         writes;

  largest_empty_square_finder_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_char    (in_cell_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_square_size (out_square_size),
    .out_top_row     (out_top_row),
    .out_left_col    (out_left_col),
    .out_grid_done   (out_grid_done)
  );

  always #4 clk = ~clk;

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_cell(int pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < pct) return book.empty_code;
    if (r < pct + (100 - pct) * 2 / 3) return book.obstacle_code;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 90) return CFG_DATA_W'($urandom_range(1, 8));
    return CFG_DATA_W'($urandom_range(9, 24));
  endfunction

  task automatic send_cell(input logic [CHAR_W-1:0] ch, output bit last);
    int g;
    g = idle_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      in_cell_char <= CHAR_W'($urandom_range(0, 255));
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cell_char <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last = book.note_cell(ch);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (book.due.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    book.set_reg(idx, val);
    writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // resize mid-grid; never widen over line buffer columns that hold no score yet
  task automatic reshape();
    logic [CFG_DATA_W-1:0] v;
    v = pick_dim();
    resizes++;
    if ($urandom_range(0, 1) == 0) write_reg(CFG_GRID_HEIGHT, v);
    else if (book.cols_ready(v)) write_reg(CFG_GRID_WIDTH, v);
    else write_reg(CFG_GRID_WIDTH, 11'd1);
  endtask

  task automatic shuffle_config();
    if ($urandom_range(0, 3) != 0) write_reg(CFG_GRID_WIDTH, pick_dim());
    if ($urandom_range(0, 3) != 0) write_reg(CFG_GRID_HEIGHT, pick_dim());
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_EMPTY_CHAR, CFG_DATA_W'($urandom_range(0, 2047)));
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_OBSTACLE_CHAR, CFG_DATA_W'($urandom_range(0, 2047)));
  endtask

  task automatic run_grid(input int pct, input bit shake);
    int  n, k;
    bit  last;
    k = shake ? $urandom_range(1, 12) : -1;
    n = 0;
    do begin
      if (n == k) begin
        settle();
        reshape();
      end
      send_cell(pick_cell(pct), last);
      n++;
    end while (!last);
    settle();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_result({out_square_size, out_top_row, out_left_col, out_grid_done});
  end

  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (n) @(negedge clk);
      n = idle_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Run did not finish in time");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int start_cells, start_grids, spin;
    int dens [5];
    bit last;
    book = new();
    dens = '{97, 85, 65, 35, 0};
    steady = 1'b0;
    resizes = 0;
    writes = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cell_char = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-cell grids at reset settings
    send_cell(EMPTY_CHAR_RST, last);
    send_cell(OBSTACLE_RST, last);
    send_cell(8'hFF, last);
    send_cell(8'h00, last);
    settle();
    write_reg(CFG_GRID_WIDTH, 11'd0);
    write_reg(CFG_GRID_HEIGHT, 11'd0);
    send_cell(EMPTY_CHAR_RST, last);
    settle();
    // empty and obstacle share one code
    write_reg(CFG_GRID_WIDTH, 11'd3);
    write_reg(CFG_GRID_HEIGHT, 11'd3);
    write_reg(CFG_EMPTY_CHAR, 11'd0);
    write_reg(CFG_OBSTACLE_CHAR, 11'd0);
    repeat (9) send_cell(8'h00, last);
    settle();
    // narrow the grid partway through its second row
    write_reg(CFG_GRID_HEIGHT, 11'd2);
    write_reg(CFG_EMPTY_CHAR, 11'h7FF);
    write_reg(CFG_OBSTACLE_CHAR, 11'h7FF);
    repeat (4) send_cell(8'hFF, last);
    settle();
    write_reg(CFG_GRID_WIDTH, 11'd2);
    send_cell(8'hFF, last);
    settle();
    // cut the height below the current row
    write_reg(CFG_GRID_HEIGHT, 11'd3);
    write_reg(CFG_EMPTY_CHAR, 11'd46);
    write_reg(CFG_OBSTACLE_CHAR, 11'd111);
    send_cell(8'd46, last);
    send_cell(8'd46, last);
    settle();
    write_reg(CFG_GRID_HEIGHT, 11'd1);
    send_cell(8'd111, last);
    send_cell(8'd46, last);
    settle();

    start_cells = book.cells;
    start_grids = book.grids;
    while (book.cells - start_cells < RANDOM_CELLS || book.grids - start_grids < RANDOM_GRIDS)
    begin
      shuffle_config();
      steady = ($urandom_range(0, 4) == 0);
      run_grid(dens[$urandom_range(0, 4)], $urandom_range(0, 5) == 0);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    for (spin = 0; spin < 5000 && book.due.size() != 0; spin++) @(negedge clk);
    repeat (4 * DRAIN) @(negedge clk);
    if (book.due.size() != 0)
      book.report($sformatf("%0d results never arrived", book.due.size()));
    $display("Covered %0d cells in %0d grids, largest square %0d, %0d register writes.",
             book.cells, book.grids, book.biggest, writes);
    $display("Grids resized while in flight: %0d; zero sizes clamped up to one.", resizes);
    if (book.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
